>>> rtl/voxel_occupancy_downsample_top_assert.svh
// Assertion macros shared by the checker.
`ifndef VOXEL_OCCUPANCY_DOWNSAMPLE_TOP_ASSERT_SVH
`define VOXEL_OCCUPANCY_DOWNSAMPLE_TOP_ASSERT_SVH
`define VOD_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define VOD_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> rtl/vod_pkg.sv
`default_nettype none
package vod_pkg;
    localparam int MaxParents = 1024;
    localparam int HashSlots  = 2048;
    localparam int CoordBits  = 16;
    localparam int SlotW  = $clog2(HashSlots);
    localparam int RowW   = $clog2(MaxParents);
    localparam int CountW = RowW + 1;
    localparam int KeyW   = 8 + 3 * CoordBits;
    localparam int PartW  = CoordBits - 1;
    localparam int EpochW = 4;
    localparam logic [31:0] HashMulHi = 32'h9E3779B9;
    localparam logic [31:0] HashMulLo = 32'h7F4A7C15;

    typedef struct packed {
        logic load;
        logic clear_step;
        logic wipe;
        logic hash_a;
        logic hash_b;
        logic probe_read;
        logic probe_next;
        logic insert;
        logic mask_write;
        logic full_mark;
        logic put;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic slot_valid;
        logic key_match;
        logic wrapped;
        logic count_full;
        logic start_req;
        logic epoch_last;
    } t_status;
endpackage
`default_nettype wire

>>> rtl/voxel_occupancy_downsample_top.sv
// One word is accepted at a time. An accepted word passes through the clear, hash, read,
// check and read-modify-write states before its result is put into the output registers;
// the read-modify-write state is skipped when a new parent cannot be stored. Each extra
// probe of the linearly probed hash table goes back through the read and check states,
// as the slot memory has a single read port. The next input word is accepted once the
// result is in the output registers; a result that is not taken holds back only the next
// result, not the next input word. After reset a pass clears the hash table before the
// first word is accepted. A start flag normally clears the table at once, but every
// fifteenth start since the last pass runs the same pass before that word is hashed.
`default_nettype none
module voxel_occupancy_downsample_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire                                 i_start_set,
    input  wire [7:0]                           i_batch_id,
    input  wire signed [vod_pkg::CoordBits-1:0] i_voxel_x,
    input  wire signed [vod_pkg::CoordBits-1:0] i_voxel_y,
    input  wire signed [vod_pkg::CoordBits-1:0] i_voxel_z,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [9:0]                          o_parent_row,
    output logic                                o_newly_added,
    output logic [7:0]                          o_parent_batch,
    output logic signed [14:0]                  o_parent_x,
    output logic signed [14:0]                  o_parent_y,
    output logic signed [14:0]                  o_parent_z,
    output logic [7:0]                          o_occupancy_mask,
    output logic [10:0]                         o_parent_total,
    output logic                                o_table_full
);
    vod_pkg::t_cmd    cmd;
    vod_pkg::t_status status;

    vod_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall), .o_cmd(cmd), .i_status(status)
    );

    vod_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_start_set(i_start_set), .i_batch_id(i_batch_id),
        .i_voxel_x(i_voxel_x), .i_voxel_y(i_voxel_y), .i_voxel_z(i_voxel_z),
        .o_parent_row(o_parent_row), .o_newly_added(o_newly_added),
        .o_parent_batch(o_parent_batch), .o_parent_x(o_parent_x),
        .o_parent_y(o_parent_y), .o_parent_z(o_parent_z),
        .o_occupancy_mask(o_occupancy_mask), .o_parent_total(o_parent_total),
        .o_table_full(o_table_full)
    );
endmodule
`default_nettype wire

>>> rtl/vod_datapath.sv
`default_nettype none
module vod_datapath (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire vod_pkg::t_cmd                  i_cmd,
    output vod_pkg::t_status                    o_status,
    input  wire                                 i_start_set,
    input  wire [7:0]                           i_batch_id,
    input  wire signed [vod_pkg::CoordBits-1:0] i_voxel_x,
    input  wire signed [vod_pkg::CoordBits-1:0] i_voxel_y,
    input  wire signed [vod_pkg::CoordBits-1:0] i_voxel_z,
    output logic [9:0]                          o_parent_row,
    output logic                                o_newly_added,
    output logic [7:0]                          o_parent_batch,
    output logic signed [14:0]                  o_parent_x,
    output logic signed [14:0]                  o_parent_y,
    output logic signed [14:0]                  o_parent_z,
    output logic [7:0]                          o_occupancy_mask,
    output logic [10:0]                         o_parent_total,
    output logic                                o_table_full
);
    localparam int SW = vod_pkg::SlotW;
    localparam int RW = vod_pkg::RowW;
    localparam int CW = vod_pkg::CountW;
    localparam int KW = vod_pkg::KeyW;
    localparam int CB = vod_pkg::CoordBits;
    localparam int EW = vod_pkg::EpochW;
    localparam int DW = EW + KW + RW;

    logic [DW-1:0] r_slot [vod_pkg::HashSlots];
    logic [7:0] r_rmask [vod_pkg::MaxParents];

    logic [KW-1:0] r_key;
    logic [2:0]    r_child;
    logic          r_start;
    logic [63:0]   r_p0;
    logic [31:0]   r_p1;
    logic [SW-1:0] r_idx;
    logic [SW:0]   r_probes;
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_clr;
    logic [EW-1:0] r_epoch;
    logic [DW-1:0] r_slot_d;
    logic [7:0]    r_mask_d;
    logic [7:0]    r_mask_new;
    logic [RW-1:0] r_row;
    logic          r_added;
    logic          r_full;
    logic [CB-1:0] px, py, pz;
    logic [63:0]   key64;
    logic [31:0]   h_hi;
    logic [63:0]   h;
    logic [63:0]   hx;
    logic [7:0]    mask_next;
    logic [SW-1:0] slot_wa;
    logic [DW-1:0] slot_wd;

    assign px = {i_voxel_x[CB-1], i_voxel_x[CB-1:1]};
    assign py = {i_voxel_y[CB-1], i_voxel_y[CB-1:1]};
    assign pz = {i_voxel_z[CB-1], i_voxel_z[CB-1:1]};
    assign key64 = 64'(r_key);
    assign h_hi = r_p0[63:32] + r_p1;
    assign h = {h_hi, r_p0[31:0]};
    assign hx = h ^ (h >> 29);
    assign mask_next = (r_added ? 8'd0 : r_mask_d) | (8'd1 << r_child);
    assign slot_wa = i_cmd.wipe ? r_clr : r_idx;
    assign slot_wd = i_cmd.wipe ? '0 : {r_epoch, r_key, r_count[RW-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= {i_batch_id, pz, py, px};
            r_child <= {i_voxel_z[0], i_voxel_y[0], i_voxel_x[0]};
            r_start <= i_start_set;
        end
        if (i_cmd.hash_a) begin
            r_p0 <= 64'(key64[31:0]) * 64'(vod_pkg::HashMulLo);
            r_p1 <= key64[31:0] * vod_pkg::HashMulHi + key64[63:32] * vod_pkg::HashMulLo;
        end
        r_slot_d <= r_slot[r_idx];
        if (i_cmd.wipe || i_cmd.insert) r_slot[slot_wa] <= slot_wd;
        r_mask_d <= r_rmask[i_cmd.insert ? r_count[RW-1:0] : r_slot_d[RW-1:0]];
        if (i_cmd.mask_write) begin
            r_rmask[r_row] <= mask_next;
            r_mask_new <= mask_next;
        end
        if (i_cmd.put) begin
            o_parent_batch <= r_key[3*CB +: 8];
            o_parent_x <= r_key[0 +: 15];
            o_parent_y <= r_key[CB +: 15];
            o_parent_z <= r_key[2*CB +: 15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0; r_clr <= '0; r_epoch <= EW'(1); r_idx <= '0; r_probes <= '0;
            r_row <= '0; r_added <= 1'b0; r_full <= 1'b0;
            o_parent_row <= '0; o_newly_added <= 1'b0; o_occupancy_mask <= '0;
            o_parent_total <= '0; o_table_full <= 1'b0;
        end else begin
            if (i_cmd.wipe) begin
                r_clr <= r_clr + 1'b1;
                if (&r_clr) begin
                    r_epoch <= EW'(1);
                    r_count <= '0;
                end
            end
            if (i_cmd.clear_step) begin
                r_epoch <= r_epoch + 1'b1;
                r_count <= '0;
            end
            if (i_cmd.hash_b) begin
                r_idx <= hx[16 +: SW];
                r_probes <= '0;
                r_added <= 1'b0;
                r_full <= 1'b0;
            end
            if (i_cmd.probe_next) begin
                r_idx <= r_idx + 1'b1;
                r_probes <= r_probes + 1'b1;
            end
            if (i_cmd.probe_read) r_row <= r_slot_d[RW-1:0];
            if (i_cmd.insert) begin
                r_row <= r_count[RW-1:0];
                r_count <= r_count + 1'b1;
                r_added <= 1'b1;
            end
            if (i_cmd.full_mark) r_full <= 1'b1;
            if (i_cmd.put) begin
                o_parent_row <= r_full ? '0 : r_row;
                o_newly_added <= r_added;
                o_occupancy_mask <= r_full ? 8'd0 : r_mask_new;
                o_parent_total <= r_count;
                o_table_full <= r_full;
            end
        end
    end

    assign o_status.clear_done = &r_clr;
    assign o_status.slot_valid = r_slot_d[DW-1 -: EW] == r_epoch;
    assign o_status.key_match  = r_slot_d[KW+RW-1:RW] == r_key;
    assign o_status.wrapped    = r_probes >= (SW+1)'(vod_pkg::HashSlots - 1);
    assign o_status.count_full = r_count >= CW'(vod_pkg::MaxParents);
    assign o_status.start_req  = r_start;
    assign o_status.epoch_last = &r_epoch;
endmodule
`default_nettype wire

>>> rtl/vod_ctrl.sv
`default_nettype none
module vod_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  wire                i_stall,
    output vod_pkg::t_cmd      o_cmd,
    input  wire vod_pkg::t_status i_status
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001, S_WIPE = 9'b000000010, S_CLR = 9'b000000100,
        S_HA = 9'b000001000, S_HB = 9'b000010000, S_RD = 9'b000100000,
        S_CHK = 9'b001000000, S_RMW = 9'b010000000, S_PUT = 9'b100000000
    } t_state;
    t_state r_state, n_state;
    logic r_item, n_item;
    logic r_out_v, n_out_v;

    always_comb begin
        n_state = r_state; n_item = r_item; o_cmd = '0;
        n_out_v = r_out_v && i_stall;
        o_stall = !(r_state == S_IDLE);
        o_valid = r_out_v;
        case (r_state)
            S_IDLE: if (i_valid) begin o_cmd.load = 1'b1; n_state = S_CLR; end
            S_WIPE: begin
                o_cmd.wipe = 1'b1;
                if (i_status.clear_done) begin
                    n_item = 1'b0;
                    n_state = r_item ? S_HA : S_IDLE;
                end
            end
            S_CLR: begin
                if (i_status.start_req && i_status.epoch_last) begin
                    n_item = 1'b1; n_state = S_WIPE;
                end else begin
                    o_cmd.clear_step = i_status.start_req;
                    n_state = S_HA;
                end
            end
            S_HA: begin o_cmd.hash_a = 1'b1; n_state = S_HB; end
            S_HB: begin o_cmd.hash_b = 1'b1; n_state = S_RD; end
            S_RD: n_state = S_CHK;
            S_CHK: begin
                if (!i_status.slot_valid) begin
                    if (i_status.count_full) begin
                        o_cmd.full_mark = 1'b1; n_state = S_PUT;
                    end else begin
                        o_cmd.insert = 1'b1; n_state = S_RMW;
                    end
                end else if (i_status.key_match) begin
                    o_cmd.probe_read = 1'b1; n_state = S_RMW;
                end else if (i_status.wrapped) begin
                    o_cmd.full_mark = 1'b1; n_state = S_PUT;
                end else begin
                    o_cmd.probe_next = 1'b1; n_state = S_RD;
                end
            end
            S_RMW: begin o_cmd.mask_write = 1'b1; n_state = S_PUT; end
            S_PUT: begin
                if (!r_out_v || !i_stall) begin
                    o_cmd.put = 1'b1; n_out_v = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WIPE; r_item <= 1'b0; r_out_v <= 1'b0;
        end else begin
            r_state <= n_state; r_item <= n_item; r_out_v <= n_out_v;
        end
    end
endmodule
`default_nettype wire

>>> rtl/vod_checker.sv
`default_nettype none
`include "voxel_occupancy_downsample_top_assert.svh"
module vod_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire        o_table_full,
    input wire        o_newly_added,
    input wire [7:0]  o_occupancy_mask,
    input wire [10:0] o_parent_total
);
    `VOD_ASSERT_IMPL(a_full_no_add, o_valid && o_table_full, !o_newly_added)
    `VOD_ASSERT_IMPL(a_mask_set, o_valid && !o_table_full, o_occupancy_mask != 8'd0)
    `VOD_ASSERT_IMPL(a_add_count, o_valid && o_newly_added, o_parent_total != 11'd0)
    `VOD_ASSERT_NEXT(a_busy, i_valid && !o_stall, o_stall)
    `VOD_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(o_parent_total) && $stable(o_occupancy_mask))
endmodule

bind voxel_occupancy_downsample_top vod_checker u_vod_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_table_full(o_table_full),
    .o_newly_added(o_newly_added), .o_occupancy_mask(o_occupancy_mask),
    .o_parent_total(o_parent_total)
);
`default_nettype wire

>>> sim/voxel_occupancy_downsample_top_tb.sv
`default_nettype none
module voxel_occupancy_downsample_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;

    typedef struct {
        logic              start_set;
        logic [7:0]        batch_id;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_voxel_word;

    typedef struct {
        logic [9:0]         row;
        logic               added;
        logic [7:0]         batch;
        logic signed [14:0] px;
        logic signed [14:0] py;
        logic signed [14:0] pz;
        logic [7:0]         mask;
        logic [10:0]        total;
        logic               full;
    } t_parent_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_start_set = 1'b0;
    logic [7:0] i_batch_id = '0;
    logic signed [15:0] i_voxel_x = '0;
    logic signed [15:0] i_voxel_y = '0;
    logic signed [15:0] i_voxel_z = '0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    logic [9:0] o_parent_row;
    logic o_newly_added;
    logic [7:0] o_parent_batch;
    logic signed [14:0] o_parent_x;
    logic signed [14:0] o_parent_y;
    logic signed [14:0] o_parent_z;
    logic [7:0] o_occupancy_mask;
    logic [10:0] o_parent_total;
    logic o_table_full;

    voxel_occupancy_downsample_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_start_set(i_start_set), .i_batch_id(i_batch_id),
        .i_voxel_x(i_voxel_x), .i_voxel_y(i_voxel_y), .i_voxel_z(i_voxel_z),
        .o_valid(o_valid), .i_stall(i_stall), .o_parent_row(o_parent_row),
        .o_newly_added(o_newly_added), .o_parent_batch(o_parent_batch),
        .o_parent_x(o_parent_x), .o_parent_y(o_parent_y), .o_parent_z(o_parent_z),
        .o_occupancy_mask(o_occupancy_mask), .o_parent_total(o_parent_total),
        .o_table_full(o_table_full)
    );

    always #5 i_clk = ~i_clk;

    t_voxel_word  pending_voxels[$];
    t_parent_word expected_parents[$];
    int unsigned  known_parents[logic [55:0]];
    logic [7:0]   row_masks[vod_pkg::MaxParents];
    int unsigned  parent_count;
    int unsigned  error_count;
    int unsigned  cycle_count;
    int unsigned  send_idle;
    int unsigned  take_idle;
    logic         stimulus_loaded;

    // In the last stretch of the run no new idle spell starts on either side.
    function automatic bit in_quiet_tail();
        return stimulus_loaded && (pending_voxels.size() < 120);
    endfunction

    function automatic t_parent_word downsample_voxel(t_voxel_word v);
        t_parent_word p;
        logic signed [15:0] hx;
        logic signed [15:0] hy;
        logic signed [15:0] hz;
        logic [55:0] key;
        int unsigned child;
        int unsigned row;
        hx = v.x >>> 1;
        hy = v.y >>> 1;
        hz = v.z >>> 1;
        child = 32'({v.z[0], v.y[0], v.x[0]});
        key = {v.batch_id, hz, hy, hx};
        if (v.start_set) begin
            known_parents.delete();
            parent_count = 0;
        end
        p.batch = v.batch_id;
        p.px = hx[14:0];
        p.py = hy[14:0];
        p.pz = hz[14:0];
        p.added = 1'b0;
        p.full = 1'b0;
        p.row = '0;
        p.mask = '0;
        row = 0;
        if (known_parents.exists(key)) begin
            row = known_parents[key];
        end else if (parent_count >= vod_pkg::MaxParents) begin
            p.full = 1'b1;
        end else begin
            row = parent_count;
            known_parents[key] = row;
            row_masks[row] = '0;
            parent_count++;
            p.added = 1'b1;
        end
        if (!p.full) begin
            row_masks[row] |= 8'(1 << child);
            p.row = row[9:0];
            p.mask = row_masks[row];
        end
        p.total = parent_count[10:0];
        return p;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch on %s: got %0d, expected %0d at cycle %0d",
                 field, got, want, cycle_count);
        error_count++;
    endtask

    task automatic queue_voxel(bit st, int b, int x, int y, int z);
        t_voxel_word v;
        v.start_set = st;
        v.batch_id = 8'(b);
        v.x = 16'(x);
        v.y = 16'(y);
        v.z = 16'(z);
        pending_voxels.insert(pending_voxels.size(), v);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_idle <= 0;
        end else if (!i_valid || !o_stall) begin
            t_voxel_word v;
            if (i_valid) begin
                expected_parents.insert(expected_parents.size(),
                    downsample_voxel('{i_start_set, i_batch_id,
                    i_voxel_x, i_voxel_y, i_voxel_z}));
            end
            if (send_idle > 0) begin
                i_valid <= 1'b0;
                send_idle <= send_idle - 1;
            end else if (!in_quiet_tail() && $urandom_range(0, 9) == 0) begin
                i_valid <= 1'b0;
                send_idle <= $urandom_range(0, 16);
            end else if (pending_voxels.size() > 0) begin
                v = pending_voxels.pop_front();
                i_valid <= 1'b1;
                i_start_set <= v.start_set;
                i_batch_id <= v.batch_id;
                i_voxel_x <= v.x;
                i_voxel_y <= v.y;
                i_voxel_z <= v.z;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            take_idle <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                t_parent_word e;
                if (expected_parents.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    e = expected_parents.pop_front();
                    if (o_table_full !== e.full)
                        report_mismatch("table_full", o_table_full, e.full);
                    if (o_parent_row !== e.row)
                        report_mismatch("parent_row", o_parent_row, e.row);
                    if (o_newly_added !== e.added)
                        report_mismatch("newly_added", o_newly_added, e.added);
                    if (o_parent_batch !== e.batch)
                        report_mismatch("parent_batch", o_parent_batch, e.batch);
                    if (o_parent_x !== e.px)
                        report_mismatch("parent_x", o_parent_x, e.px);
                    if (o_parent_y !== e.py)
                        report_mismatch("parent_y", o_parent_y, e.py);
                    if (o_parent_z !== e.pz)
                        report_mismatch("parent_z", o_parent_z, e.pz);
                    if (o_occupancy_mask !== e.mask)
                        report_mismatch("occupancy_mask", o_occupancy_mask, e.mask);
                    if (o_parent_total !== e.total)
                        report_mismatch("parent_total", o_parent_total, e.total);
                end
            end
            if (take_idle > 0) begin
                i_stall <= 1'b1;
                take_idle <= take_idle - 1;
            end else if (!in_quiet_tail() && $urandom_range(0, 9) == 0) begin
                i_stall <= 1'b1;
                take_idle <= $urandom_range(0, 16);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int bx;
        int by;
        int bz;
        int b;
        cycle_count = 0;
        error_count = 0;
        parent_count = 0;
        stimulus_loaded = 1'b0;

        queue_voxel(1, 0, 0, 0, 0);
        queue_voxel(0, 255, 32767, -32768, -1);
        queue_voxel(0, 255, 32766, -32767, -2);
        queue_voxel(0, 0, -32768, 32767, 32767);
        for (int c = 0; c < 8; c++)
            queue_voxel(0, 7, -4 + c[0], -6 + c[1], 10 + c[2]);
        queue_voxel(0, 8, -4, -6, 10);
        queue_voxel(0, 7, -3, -5, 11);
        queue_voxel(0, 1, -1, -1, -1);
        queue_voxel(0, 1, -2, -2, -2);
        queue_voxel(1, 1, -1, -1, -1);
        queue_voxel(1, 255, -32768, -32768, -32768);
        queue_voxel(0, 170, 21845, -21846, 1);

        // A run of distinct parents, then revisits of the same parents.
        queue_voxel(1, 3, 0, 0, 0);
        for (int i = 1; i < 24; i++)
            queue_voxel(0, 3, 2 * i, 0, 0);
        for (int i = 0; i < 12; i++)
            queue_voxel(0, 3, 2 * i + 1, $urandom_range(0, 1), $urandom_range(0, 1));
        for (int i = 0; i < 6; i++)
            queue_voxel(0, $urandom, $urandom, $urandom, $urandom);

        for (int g = 0; g < 40; g++) begin
            bx = $urandom_range(0, 65535);
            by = $urandom_range(0, 65535);
            bz = $urandom_range(0, 65535);
            b = $urandom_range(0, 255);
            queue_voxel($urandom_range(0, 2) == 0, b, bx, by, bz);
            for (int i = 0; i < 15; i++) begin
                if ($urandom_range(0, 7) == 0)
                    queue_voxel($urandom_range(0, 30) == 0, $urandom, $urandom,
                                $urandom, $urandom);
                else
                    queue_voxel(0, b + $urandom_range(0, 1), bx + $urandom_range(0, 5),
                                by + $urandom_range(0, 5), bz + $urandom_range(0, 5));
            end
        end
        stimulus_loaded = 1'b1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_voxels.size() > 0 || i_valid || expected_parents.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> voxel_occupancy_downsample_top.f
+incdir+rtl
rtl/vod_pkg.sv
rtl/vod_datapath.sv
rtl/vod_ctrl.sv
rtl/voxel_occupancy_downsample_top.sv
rtl/vod_checker.sv
sim/voxel_occupancy_downsample_top_tb.sv
